@@ rtl/dttf_pkg.sv @@
// ----------------------------------------------------------------------------
// dttf_pkg
// Shared types and constants of the decimal text to fixed-point converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dttf_pkg;

    localparam int VALUE_W    = 48;  // output value width, two's complement
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int FRAC_ACC_W = 30;  // holds up to nine decimal digits
    localparam int FRAC_CNT_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_CHAR,
        ST_START,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic take;      // a character transaction completes this cycle
        logic start;     // load the fraction divider
        logic step;      // one quotient bit
        logic load_out;  // load the result register and clear the accumulators
    } dttf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } dttf_status_t;

    // Power of ten for a count of fraction digits.
    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] p;
        begin
            case (n)
                4'd0:    p = 30'd1;
                4'd1:    p = 30'd10;
                4'd2:    p = 30'd100;
                4'd3:    p = 30'd1000;
                4'd4:    p = 30'd10000;
                4'd5:    p = 30'd100000;
                4'd6:    p = 30'd1000000;
                4'd7:    p = 30'd10000000;
                4'd8:    p = 30'd100000000;
                default: p = 30'd1000000000;
            endcase
            return p;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/dttf_char_if.sv @@
// ----------------------------------------------------------------------------
// dttf_char_if
// Character stream channel: one ASCII code per transaction with a last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface dttf_char_if import dttf_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);

endinterface

`default_nettype wire

@@ rtl/dttf_result_if.sv @@
// ----------------------------------------------------------------------------
// dttf_result_if
// Result channel: one signed fixed-point value and an overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dttf_result_if import dttf_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;

    modport source (output valid, output value, output overflow, input ready);
    modport sink   (input valid, input value, input overflow, output ready);

endinterface

`default_nettype wire

@@ rtl/decimal_text_to_fixed_point.sv @@
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// ASCII decimal string to signed fixed-point converter.
// ----------------------------------------------------------------------------
// Characters of one number arrive one per transaction, at one per cycle
// while the block takes characters, and the transaction with last set ends
// the string. A leading '-' negates, the first '.' separates the integer and
// fraction parts, and any other non-digit counts as a zero digit. The result
// carries FRAC_BITS fraction bits, truncated toward zero; an integer part
// past its range saturates the magnitude and sets overflow. After the last
// character the block loads the fraction divider, which produces one
// quotient bit per cycle, and then loads the result register; no character
// of the next string is taken before that. The result register load
// stretches for as long as the previous result still waits on the result
// channel. The result register holds a finished value while the next string
// is taken in.
`default_nettype none

module decimal_text_to_fixed_point import dttf_pkg::*; #(
    parameter int INT_BITS        = 31,
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dttf_char_if.sink     chars,
    dttf_result_if.source result
);

    // Integer part width: limited both by INT_BITS and by the 48-bit output.
    localparam int INT_W = (INT_BITS < VALUE_W - 1 - FRAC_BITS) ?
                           INT_BITS : VALUE_W - 1 - FRAC_BITS;

    dttf_cmd_t    cmd;
    dttf_status_t status;
    logic         in_ready;

    dttf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_last  (chars.last),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    dttf_datapath #(
        .INT_W           (INT_W),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .char_code    (chars.char_code),
        .out_ready    (result.ready),
        .status       (status),
        .out_valid    (result.valid),
        .out_value    (result.value),
        .out_overflow (result.overflow)
    );

    assign chars.ready = in_ready;

endmodule

`default_nettype wire

@@ rtl/dttf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dttf_ctrl
// Sequencer: takes characters, then runs the fraction divider and hands the
// finished value to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dttf_ctrl import dttf_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_last,
    input  wire dttf_status_t status,
    output logic              in_ready,
    output dttf_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CHAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CHAR:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_CHAR;
                end
            end
            default:
            begin
                state_next = ST_CHAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_CHAR:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_START:
            begin
                cmd.start = 1'b1;
            end
            ST_DIV:
            begin
                cmd.step = !status.div_done;
            end
            ST_DONE:
            begin
                cmd.load_out = !status.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/dttf_datapath.sv @@
// ----------------------------------------------------------------------------
// dttf_datapath
// Digit accumulators, a bit-serial fraction divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dttf_datapath import dttf_pkg::*; #(
    parameter int INT_W           = 31,
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dttf_cmd_t                 cmd,
    input  wire logic [CHAR_W-1:0]         char_code,
    input  wire logic                      out_ready,
    output dttf_status_t                   status,
    output logic                           out_valid,
    output logic signed [VALUE_W-1:0]      out_value,
    output logic                           out_overflow
);

    localparam int MAG_W = INT_W + FRAC_BITS;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [FRAC_CNT_W-1:0] MAX_CNT = FRAC_CNT_W'(MAX_FRAC_DIGITS);

    logic [INT_W-1:0]      int_reg,   int_next;
    logic [FRAC_ACC_W-1:0] frac_reg,  frac_next;
    logic [FRAC_CNT_W-1:0] fcnt_reg,  fcnt_next;
    logic                  point_reg, point_next;
    logic                  neg_reg,   neg_next;
    logic                  first_reg, first_next;
    logic                  ovf_reg,   ovf_next;

    logic [FRAC_ACC_W-1:0] rem_reg;
    logic [FRAC_BITS-1:0]  quo_reg;
    logic [CNT_W-1:0]      bit_cnt_reg;
    logic                  out_valid_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic                  out_ovf_reg;

    logic                  is_digit;
    logic [DIGIT_W-1:0]    digit;
    logic [INT_W+3:0]      int_ext;
    logic [INT_W+3:0]      int_mul;
    logic [FRAC_ACC_W+3:0] frac_ext;
    logic [FRAC_ACC_W+3:0] frac_mul;

    logic [FRAC_ACC_W:0]   rem_dbl;
    logic [FRAC_ACC_W:0]   div_ext;
    logic [FRAC_ACC_W:0]   rem_diff;
    logic                  rem_ge;

    logic [MAG_W-1:0]      mag;
    logic [VALUE_W-1:0]    mag_ext;
    logic [VALUE_W-1:0]    value_calc;

    // Character decode and digit accumulation.
    always_comb
    begin
        is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        digit    = is_digit ? DIGIT_W'(char_code - CHAR_ZERO) : '0;
        int_ext  = {4'b0000, int_reg};
        int_mul  = (int_ext << 3) + (int_ext << 1) + {{INT_W{1'b0}}, digit};
        frac_ext = {4'b0000, frac_reg};
        frac_mul = (frac_ext << 3) + (frac_ext << 1) + {{FRAC_ACC_W{1'b0}}, digit};

        int_next   = int_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        point_next = point_reg;
        neg_next   = neg_reg;
        first_next = first_reg;
        ovf_next   = ovf_reg;

        if (cmd.load_out)
        begin
            int_next   = '0;
            frac_next  = '0;
            fcnt_next  = '0;
            point_next = 1'b0;
            neg_next   = 1'b0;
            first_next = 1'b1;
            ovf_next   = 1'b0;
        end
        else if (cmd.take)
        begin
            first_next = 1'b0;
            if (first_reg && (char_code == CHAR_MINUS))
            begin
                neg_next = 1'b1;
            end
            else if ((char_code == CHAR_POINT) && !point_reg)
            begin
                point_next = 1'b1;
            end
            else if (!point_reg)
            begin
                if (!ovf_reg)
                begin
                    // Anything that reaches the top four bits is past the limit.
                    if (int_mul[INT_W+3:INT_W] != 4'b0000)
                    begin
                        ovf_next = 1'b1;
                        int_next = '1;
                    end
                    else
                    begin
                        int_next = int_mul[INT_W-1:0];
                    end
                end
            end
            else if (fcnt_reg < MAX_CNT)
            begin
                frac_next = frac_mul[FRAC_ACC_W-1:0];
                fcnt_next = fcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg       <= '0;
            frac_reg      <= '0;
            fcnt_reg      <= '0;
            point_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            first_reg     <= 1'b1;
            ovf_reg       <= 1'b0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            point_reg <= point_next;
            neg_reg   <= neg_next;
            first_reg <= first_next;
            ovf_reg   <= ovf_next;
            if (cmd.start)
            begin
                bit_cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Restoring division of the kept fraction digits by ten to their count,
    // one quotient bit per step. The remainder always stays below the divisor.
    always_comb
    begin
        rem_dbl  = {rem_reg, 1'b0};
        div_ext  = {1'b0, pow10(fcnt_reg)};
        rem_ge   = rem_dbl >= div_ext;
        rem_diff = rem_dbl - div_ext;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= frac_reg;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_ge ? rem_diff[FRAC_ACC_W-1:0] : rem_dbl[FRAC_ACC_W-1:0];
            quo_reg <= {quo_reg[FRAC_BITS-2:0], rem_ge};
        end
        if (cmd.load_out)
        begin
            out_value_reg <= value_calc;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_comb
    begin
        mag        = ovf_reg ? {MAG_W{1'b1}} : {int_reg, quo_reg};
        mag_ext    = VALUE_W'(mag);
        value_calc = neg_reg ? (~mag_ext + 1'b1) : mag_ext;
    end

    assign status.div_done = (bit_cnt_reg == CNT_W'(FRAC_BITS));
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_overflow = out_ovf_reg;

endmodule

`default_nettype wire

@@ sim/tb_decimal_text_to_fixed_point.sv @@
// ----------------------------------------------------------------------------
// tb_decimal_text_to_fixed_point
// Self-checking testbench of the decimal text to fixed-point converter.
// ----------------------------------------------------------------------------
// Whole number strings go into the character channel, one character per
// transaction, and a scoreboard works out the fixed-point value and the
// overflow flag of each string. Every result transaction is checked against
// the oldest pending value. A short directed list covers the corner cases.
// Random strings then follow, mostly well-formed numbers and some broken
// text or noise, in three phases with different idle and stall rates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_decimal_text_to_fixed_point;
    timeunit 1ns;
    timeprecision 1ps;
    import dttf_pkg::*;

    localparam int INT_BITS        = 31;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int CHARS_PER_PHASE = 285;
    localparam int STALL_LIMIT     = 4000;

    localparam logic [63:0] MAG_MAX      = (64'd1 << (VALUE_W - 1)) - 64'd1;
    localparam logic [63:0] INT_CAP_BITS = (64'd1 << INT_BITS) - 64'd1;
    localparam logic [63:0] INT_CAP_FIT  = MAG_MAX >> FRAC_BITS;
    localparam logic [63:0] INT_LIMIT    =
        (INT_CAP_BITS < INT_CAP_FIT) ? INT_CAP_BITS : INT_CAP_FIT;
    localparam logic [63:0] FRAC_ONES    = (64'd1 << FRAC_BITS) - 64'd1;

    typedef logic [CHAR_W-1:0] text_t[$];

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } fixed_result_t;

    class fixed_point_scoreboard;
        logic [63:0]   int_part;
        logic [63:0]   frac_part;
        int            frac_cnt;
        bit            point_taken;
        bit            negative;
        bit            at_start;
        bit            saturated;
        fixed_result_t expected_q[$];
        int            errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            int_part    = '0;
            frac_part   = '0;
            frac_cnt    = 0;
            point_taken = 1'b0;
            negative    = 1'b0;
            at_start    = 1'b1;
            saturated   = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Feed one accepted character; the last one of a string queues its value.
        function void note_char(input logic [CHAR_W-1:0] code, input logic mark);
            logic [63:0]   digit;
            logic [63:0]   sum;
            logic [63:0]   mag;
            logic [63:0]   frac;
            logic [63:0]   scale;
            logic [63:0]   signed_mag;
            bit            sign_char;
            fixed_result_t res;
            sign_char = 1'b0;
            if (at_start) begin
                at_start = 1'b0;
                if (code == CHAR_MINUS) begin
                    negative  = 1'b1;
                    sign_char = 1'b1;
                end
            end
            if (!sign_char) begin
                if (code == CHAR_POINT && !point_taken) begin
                    point_taken = 1'b1;
                end
                else begin
                    digit = (code >= CHAR_ZERO && code <= CHAR_NINE) ?
                            64'(code - CHAR_ZERO) : 64'd0;
                    if (!point_taken) begin
                        if (!saturated) begin
                            sum = int_part * 64'd10 + digit;
                            if (sum > INT_LIMIT) begin
                                saturated = 1'b1;
                                int_part  = INT_LIMIT;
                            end
                            else begin
                                int_part = sum;
                            end
                        end
                    end
                    else if (frac_cnt < MAX_FRAC_DIGITS) begin
                        frac_part = frac_part * 64'd10 + digit;
                        frac_cnt++;
                    end
                end
            end
            if (mark) begin
                if (saturated) begin
                    mag = (INT_LIMIT << FRAC_BITS) | FRAC_ONES;
                end
                else begin
                    scale = 64'd1;
                    for (int i = 0; i < frac_cnt; i++)
                        scale = scale * 64'd10;
                    frac = (frac_part << FRAC_BITS) / scale;
                    mag  = (int_part << FRAC_BITS) | (frac & FRAC_ONES);
                end
                if (mag > MAG_MAX)
                    mag = MAG_MAX;
                signed_mag   = negative ? (64'd0 - mag) : mag;
                res.value    = signed_mag[VALUE_W-1:0];
                res.overflow = saturated;
                expected_q.push_back(res);
                clear();
            end
        endfunction

        task check_result(input logic [VALUE_W-1:0] value, input logic overflow);
            fixed_result_t exp_res;
            if (expected_q.size() == 0) begin
                report($sformatf("result value=%h overflow=%b with no string pending",
                                 value, overflow));
            end
            else begin
                exp_res = expected_q.pop_front();
                if (value !== exp_res.value)
                    report($sformatf("value %h, expected %h", value, exp_res.value));
                if (overflow !== exp_res.overflow)
                    report($sformatf("overflow %b, expected %b",
                                     overflow, exp_res.overflow));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    dttf_char_if   chars_if ();
    dttf_result_if result_if ();

    decimal_text_to_fixed_point #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if)
    );

    fixed_point_scoreboard sb = new();

    int src_idle_pct   = 12;
    int sink_stall_pct = 52;
    int chars_sent     = 0;
    int quiet_cycles   = 0;
    bit took_any;

    string directed_texts[] = '{
        "0", "9", "-", ".", "-.", "-0", "12.5", "-12.5",
        "2147483647", "-2147483647", "2147483648", "-99999999999.5",
        "0.999999999", "3.14159265358979", "1.2.3", "12-3", "--5",
        "4a2.b1", "-.0625", "00000000000000000000123", "999.0000000001"
    };

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The result side stalls at the rate of the current phase.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            took_any = 1'b0;
            if (chars_if.valid && chars_if.ready) begin
                sb.note_char(chars_if.char_code, chars_if.last);
                took_any = 1'b1;
            end
            if (result_if.valid && result_if.ready) begin
                sb.check_result(result_if.value, result_if.overflow);
                took_any = 1'b1;
            end
            quiet_cycles = took_any ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] code, input logic mark);
        while ($urandom_range(99) < src_idle_pct) begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= code;
        chars_if.last      <= mark;
        do
            @(posedge clk);
        while (!chars_if.ready);
        chars_sent++;
    endtask

    task automatic send_text(input text_t t);
        for (int i = 0; i < t.size(); i++)
            send_char(t[i], i == t.size() - 1);
    endtask

    task automatic send_string(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        send_text(t);
    endtask

    // Hold the character channel idle until every string has come back.
    task automatic wait_drained();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic text_t random_text();
        text_t t;
        int    kind;
        int    n_int;
        int    n_frac;
        string near_limit;
        kind       = $urandom_range(99);
        near_limit = "214748364";
        if (kind < 75) begin
            if ($urandom_range(99) < 40)
                t.push_back(CHAR_MINUS);
            if ($urandom_range(19) == 0) begin
                // Integer parts right at the edge of the range.
                for (int i = 0; i < near_limit.len(); i++)
                    t.push_back(near_limit[i]);
                n_int = $urandom_range(2);
            end
            else begin
                n_int = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
            end
            repeat (n_int)
                t.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
            if ($urandom_range(99) < 70) begin
                t.push_back(CHAR_POINT);
                n_frac = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(5);
                repeat (n_frac)
                    t.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
            end
            if (t.size() == 0)
                t.push_back(CHAR_ZERO);
            if ($urandom_range(9) == 0)
                t[$urandom_range(t.size() - 1)] = CHAR_W'($urandom_range(255));
        end
        else if (kind < 90) begin
            repeat ($urandom_range(8, 1)) begin
                case ($urandom_range(3))
                    0:       t.push_back(CHAR_MINUS);
                    1:       t.push_back(CHAR_POINT);
                    2:       t.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
                    default: t.push_back(CHAR_W'($urandom_range(255)));
                endcase
            end
        end
        else begin
            repeat ($urandom_range(6, 1))
                t.push_back(CHAR_W'($urandom_range(255)));
        end
        return t;
    endfunction

    initial begin
        text_t odd_text;
        chars_if.valid     = 1'b0;
        chars_if.char_code = '0;
        chars_if.last      = 1'b0;
        rst_n              = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_texts[i])
            send_string(directed_texts[i]);
        odd_text = '{8'h00};
        send_text(odd_text);
        odd_text = '{8'h37, 8'hFF, 8'h35};
        send_text(odd_text);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 12;
                    sink_stall_pct = 52;
                end
                1:
                begin
                    src_idle_pct   = 52;
                    sink_stall_pct = 12;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            while (chars_sent < (phase + 1) * CHARS_PER_PHASE)
                send_text(random_text());
            wait_drained();
        end

        repeat (FRAC_BITS + 20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
